### rtl/core/spdpi_pkg.sv
// spdpi_pkg: types, constants and microprogram ROM of the speed PI controller.
// No dependencies; used by the sequencer, datapath and top level.
`default_nettype none

package spdpi_pkg;

  localparam int unsigned StepW = 4;

  // speed conversion constant: round(9.549296585513721e-3 * 2^32)
  localparam logic signed [26:0] SpdK = 27'sd41013917;

  localparam logic [1:0] CfgSpdLim = 2'd0;
  localparam logic [1:0] CfgTrqLim = 2'd1;
  localparam logic [1:0] CfgKp     = 2'd2;
  localparam logic [1:0] CfgKi     = 2'd3;

  localparam logic [14:0] SpdLimRst = 15'd3000;
  localparam logic [14:0] TrqLimRst = 15'd30000;
  localparam logic [23:0] KpRst     = 24'd33554;
  localparam logic [23:0] KiRst     = 24'd839;

  localparam logic [StepW-1:0] StepWait   = 4'd0;
  localparam logic [StepW-1:0] StepMulSpd = 4'd1;
  localparam logic [StepW-1:0] StepRpm    = 4'd2;
  localparam logic [StepW-1:0] StepErr    = 4'd3;
  localparam logic [StepW-1:0] StepGate   = 4'd4;
  localparam logic [StepW-1:0] StepKpt    = 4'd5;
  localparam logic [StepW-1:0] StepInteg  = 4'd6;
  localparam logic [StepW-1:0] StepUnsat  = 4'd7;
  localparam logic [StepW-1:0] StepMag    = 4'd8;
  localparam logic [StepW-1:0] StepM1000  = 4'd9;
  localparam logic [StepW-1:0] StepEmit   = 4'd10;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_SPD,
    MUL_KP,
    MUL_KI
  } mul_e;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_RPM,
    ALU_ERR,
    ALU_GATE,
    ALU_KPT,
    ALU_INTEG,
    ALU_UNSAT,
    ALU_MAG,
    ALU_M1000
  } alu_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_IF_MODE
  } jmp_e;

  typedef struct packed {
    logic             wait_in;
    logic             emit;
    mul_e             mul_sel;
    alu_e             alu_op;
    jmp_e             jmp;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic mode;
    logic out_space;
  } stat_t;

  function automatic ctrl_t ucode_rom(input logic [StepW-1:0] step);
    ctrl_t w;
    w.wait_in = 1'b0;
    w.emit    = 1'b0;
    w.mul_sel = MUL_NONE;
    w.alu_op  = ALU_NOP;
    w.jmp     = JMP_NEXT;
    w.target  = StepWait;
    unique case (step)
      StepWait: begin
        w.wait_in = 1'b1;
        w.jmp     = JMP_IF_MODE;
      end
      StepMulSpd: w.mul_sel = MUL_SPD;
      StepRpm:    w.alu_op  = ALU_RPM;
      StepErr:    w.alu_op  = ALU_ERR;
      StepGate: begin
        w.alu_op  = ALU_GATE;
        w.mul_sel = MUL_KP;
      end
      StepKpt: begin
        w.alu_op  = ALU_KPT;
        w.mul_sel = MUL_KI;
      end
      StepInteg:  w.alu_op = ALU_INTEG;
      StepUnsat:  w.alu_op = ALU_UNSAT;
      StepMag:    w.alu_op = ALU_MAG;
      StepM1000:  w.alu_op = ALU_M1000;
      StepEmit: begin
        w.emit = 1'b1;
        w.jmp  = JMP_ALWAYS;
      end
      default:    w.jmp = JMP_ALWAYS;
    endcase
    return w;
  endfunction

  // saturate a 43-bit signed value to 40 bits
  function automatic logic signed [39:0] sat40(input logic signed [42:0] x);
    logic signed [39:0] r;
    if (x[42:39] == 4'b0000 || x[42:39] == 4'b1111) begin
      r = x[39:0];
    end else if (x[42]) begin
      r = {1'b1, 39'd0};
    end else begin
      r = {1'b0, {39{1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/spdpi_if.sv
// spdpi_in_if / spdpi_out_if: valid/ready channels for input and result items.
// No dependencies.
`default_nettype none

interface spdpi_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] ref_rpm;
  logic signed [21:0] speed_mrad;

  modport source (output valid, mode, ref_rpm, speed_mrad, input ready);
  modport sink   (input valid, mode, ref_rpm, speed_mrad, output ready);
endinterface

interface spdpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] torque_mnm;

  modport source (output valid, torque_mnm, input ready);
  modport sink   (input valid, torque_mnm, output ready);
endinterface

`default_nettype wire

### rtl/core/spdpi_seq.sv
// spdpi_seq: step counter and microprogram ROM lookup with conditional jumps.
// Depends on spdpi_pkg.
`default_nettype none

module spdpi_seq
  import spdpi_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  logic [StepW-1:0] pc_q, pc_d;
  logic             hold;

  assign ctrl_o = ucode_rom(pc_q);
  assign hold   = (ctrl_o.wait_in && !stat_i.in_fire) || (ctrl_o.emit && !stat_i.out_space);

  always_comb begin
    pc_d = pc_q;
    if (!hold) begin
      unique case (ctrl_o.jmp)
        JMP_NEXT:    pc_d = StepW'(pc_q + 1'b1);
        JMP_ALWAYS:  pc_d = ctrl_o.target;
        JMP_IF_MODE: pc_d = stat_i.mode ? ctrl_o.target : StepW'(pc_q + 1'b1);
        default:     pc_d = StepWait;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/spdpi_dp.sv
// spdpi_dp: datapath with config registers, shared 27x27 multiplier, state
// registers and output register. Depends on spdpi_pkg and spdpi_if.
`default_nettype none

module spdpi_dp
  import spdpi_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_idx_i,
  input  wire  [23:0]  cfg_wdata_i,
  input  ctrl_t        ctrl_i,
  output stat_t        stat_o,
  spdpi_in_if.sink     in_i,
  spdpi_out_if.source  out_o
);

  logic [14:0] spd_lim_q, trq_lim_q;
  logic [23:0] kp_q, ki_q;

  logic signed [15:0] ref_q, ref_d, lim_s;
  logic signed [21:0] spd_q;
  logic signed [26:0] mul_a, mul_b;
  logic signed [53:0] mul_res, prod_q, rnd;
  logic signed [23:0] rpm_q;
  logic signed [24:0] err_q, err_d, gated_d, pgate_q;
  logic signed [25:0] sum_q, sum_d;
  logic signed [40:0] kpt_q;
  logic signed [39:0] integ_q, unsat_q;
  logic [39:0]        mag_q;
  logic [49:0]        m1000_d;
  logic [48:0]        m1000_q;
  logic               awin_ok, in_fire, emit_fire, out_valid_q;
  logic [24:0]        mnm_mag;
  logic [14:0]        mnm_clamp;
  logic signed [15:0] torque_d, torque_q;

  assign in_i.ready       = ctrl_i.wait_in;
  assign in_fire          = in_i.valid && ctrl_i.wait_in;
  assign stat_o.in_fire   = in_fire;
  assign stat_o.mode      = in_i.mode;
  assign stat_o.out_space = !out_valid_q || out_o.ready;
  assign emit_fire        = ctrl_i.emit && stat_o.out_space;

  assign lim_s = $signed({1'b0, spd_lim_q});
  always_comb begin
    ref_d = in_i.ref_rpm;
    if (in_i.ref_rpm > lim_s) begin
      ref_d = lim_s;
    end else if (in_i.ref_rpm < -lim_s) begin
      ref_d = -lim_s;
    end
  end

  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_SPD: begin
        mul_a = {{5{spd_q[21]}}, spd_q};
        mul_b = SpdK;
      end
      MUL_KP: begin
        mul_a = $signed({3'b000, kp_q});
        mul_b = {{2{err_q[24]}}, err_q};
      end
      MUL_KI: begin
        mul_a = $signed({3'b000, ki_q});
        mul_b = {sum_q[25], sum_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_res = mul_a * mul_b;

  // rpm Q8, round to nearest
  assign rnd   = prod_q + 54'sh800000;
  assign err_d = $signed({ref_q[15], ref_q, 8'h00}) - $signed({rpm_q[23], rpm_q});

  // anti-windup: previous unclamped torque below limit, or opposing the error
  assign awin_ok = (m1000_q < {10'd0, trq_lim_q, 24'd0}) ||
                   (!unsat_q[39] && unsat_q != '0 && err_q[24]) ||
                   (unsat_q[39] && !err_q[24] && err_q != '0);
  assign gated_d = awin_ok ? err_q : '0;
  assign sum_d   = {gated_d[24], gated_d} + {pgate_q[24], pgate_q};

  assign m1000_d = {mag_q, 10'd0} - {6'd0, mag_q, 4'd0} - {7'd0, mag_q, 3'd0};

  assign mnm_mag   = m1000_q[48:24];
  assign mnm_clamp = (mnm_mag > {10'd0, trq_lim_q}) ? trq_lim_q : mnm_mag[14:0];
  assign torque_d  = unsat_q[39] ? -$signed({1'b0, mnm_clamp}) : $signed({1'b0, mnm_clamp});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_lim_q <= SpdLimRst;
      trq_lim_q <= TrqLimRst;
      kp_q      <= KpRst;
      ki_q      <= KiRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSpdLim: spd_lim_q <= cfg_wdata_i[14:0];
        CfgTrqLim: trq_lim_q <= cfg_wdata_i[14:0];
        CfgKp:     kp_q      <= cfg_wdata_i;
        CfgKi:     ki_q      <= cfg_wdata_i;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      pgate_q <= '0;
      unsat_q <= '0;
      m1000_q <= '0;
    end else if (in_fire && in_i.mode) begin
      integ_q <= '0;
      pgate_q <= '0;
      unsat_q <= '0;
      m1000_q <= '0;
    end else begin
      case (ctrl_i.alu_op)
        ALU_GATE:  pgate_q <= gated_d;
        ALU_INTEG: integ_q <= sat40({{3{integ_q[39]}}, integ_q} + prod_q[50:8]);
        ALU_UNSAT: unsat_q <= sat40({{3{integ_q[39]}}, integ_q} + {{2{kpt_q[40]}}, kpt_q});
        ALU_M1000: m1000_q <= m1000_d[48:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ref_q <= ref_d;
      spd_q <= in_i.speed_mrad;
    end
    if (ctrl_i.mul_sel != MUL_NONE) begin
      prod_q <= mul_res;
    end
    case (ctrl_i.alu_op)
      ALU_RPM:  rpm_q <= rnd[47:24];
      ALU_ERR:  err_q <= err_d;
      ALU_GATE: sum_q <= sum_d;
      ALU_KPT:  kpt_q <= prod_q[48:8];
      ALU_MAG:  mag_q <= unsat_q[39] ? 40'(-unsat_q) : 40'(unsat_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      torque_q <= torque_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.torque_mnm = torque_q;

endmodule

`default_nettype wire

### rtl/core/speed_pi_antiwindup.sv
// speed_pi_antiwindup: speed PI controller with conditional trapezoidal integration.
// A run item is taken only in the wait step; the next one waits until the microprogram
// has run through its emit step, as its steps share the single 27x27 multiplier;
// the emit step waits while a held result is not taken.
// A clear item gives no result and leaves the block ready for the next item.
// Reset (async, active low): registers to defaults, controller state to zero.
// Depends on spdpi_pkg, spdpi_if, spdpi_seq, spdpi_dp.
`default_nettype none

module speed_pi_antiwindup
  import spdpi_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_idx_i,
  input  wire  [23:0]  cfg_wdata_i,
  spdpi_in_if.sink     in_i,
  spdpi_out_if.source  out_o
);

  ctrl_t ctrl;
  stat_t stat;

  spdpi_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  spdpi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_i        (in_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

### rtl/core/spdpi_checker.sv
// spdpi_checker: port-level assertions for speed_pi_antiwindup, bound to the top.
// Depends on speed_pi_antiwindup and spdpi_if.
`default_nettype none

module spdpi_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_i,
  input wire in_mode_i,
  input wire out_valid_i,
  input wire out_ready_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_mode_i |=> !in_ready_i)
    else $error("ready after run item accepted");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_mode_i |=> in_ready_i)
    else $error("clear item left block busy");

  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result item without a run in progress");

endmodule

bind speed_pi_antiwindup spdpi_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

`default_nettype wire
